// ===== design/mtep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the track event parser
// Result kinds, the classified byte token and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] StatusHighMask = 8'hF0;
  localparam logic [7:0] NibbleMask     = 8'h0F;
  localparam logic [7:0] DataMask       = 8'h7F;
  localparam logic [7:0] StatusBit      = 8'h80;
  localparam logic [7:0] MetaStatus     = 8'hFF;
  localparam logic [7:0] SysexStatus    = 8'hF0;
  localparam logic [7:0] SysexEnd       = 8'hF7;
  localparam logic [7:0] MetaEndOfTrack = 8'h2F;
  localparam logic [3:0] MetaChannel    = 4'hF;

  typedef enum logic [3:0] {
    KindNoteOff   = 4'd0,
    KindNoteOn    = 4'd1,
    KindPolyPress = 4'd2,
    KindControl   = 4'd3,
    KindProgram   = 4'd4,
    KindChanPress = 4'd5,
    KindBend      = 4'd6,
    KindMeta      = 4'd7,
    KindMetaData  = 4'd8,
    KindSysex     = 4'd9,
    KindTruncated = 4'd10
  } event_kind_e;

  // One track byte with its classification flags.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       is_status;
    logic       is_chan_status;
    logic       is_meta;
    logic       is_sysex;
    logic       is_sysex_end;
    logic       is_end_of_track;
  } token_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [3:0]  channel;
    logic [27:0] delta_ticks;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [15:0] bend_word;
    logic [7:0]  meta_type;
    logic [7:0]  meta_length;
    logic        track_done;
  } result_t;

endpackage

// ===== design/midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser: track chunk event parser
// Turns the byte stream of a track chunk into one record per event.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one track byte per item (byte_value_i) with
//   last_byte_i marking the final byte of the chunk. The output channel
//   gives at most one result item per input byte: channel messages, meta
//   headers, meta payload bytes, sysex ends, skipped F-status events, or a
//   truncated marker when the chunk ends inside an event.
//   Both channels move an item when valid is high and stall is low.
//   Throughput is one byte per clock, set by the parser in the back end,
//   which consumes one queued byte each cycle its result register is free.
//   Each byte passes through the token queue and then the result register
//   before the receiver can take its result.
//   When the receiver stalls, the result register holds and the parser
//   stops; the token queue absorbs up to QueueDepth bytes before the input
//   stall rises. Reset empties the queue, drops any pending result and sets
//   the parser to expect a delta time with no running status.
//   Once the track has ended, bytes are still accepted and dropped.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
  parameter int unsigned QueueDepth = mtep_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_kind_o,
  output logic [3:0]  channel_o,
  output logic [27:0] delta_ticks_o,
  output logic [7:0]  data_first_o,
  output logic [7:0]  data_second_o,
  output logic [15:0] bend_word_o,
  output logic [7:0]  meta_type_o,
  output logic [7:0]  meta_length_o,
  output logic        track_done_o
);

  mtep_pkg::token_t  in_token;
  mtep_pkg::token_t  head_token;
  mtep_pkg::result_t result;
  logic              queue_full;
  logic              queue_valid;
  logic              queue_pop;

  // Front end: classify the byte as it arrives.
  mtep_front u_front (
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .token_o      (in_token)
  );

  // The queue lets the input keep flowing while the output is stalled.
  mtep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_token_i (in_token),
    .full_o       (queue_full),
    .pop_i        (queue_pop),
    .valid_o      (queue_valid),
    .head_o       (head_token)
  );

  assign in_stall_o = queue_full;

  // Back end: the parser state machine and the result register.
  mtep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .token_valid_i (queue_valid),
    .token_i       (head_token),
    .token_pop_o   (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  assign event_kind_o  = result.event_kind;
  assign channel_o     = result.channel;
  assign delta_ticks_o = result.delta_ticks;
  assign data_first_o  = result.data_first;
  assign data_second_o = result.data_second;
  assign bend_word_o   = result.bend_word;
  assign meta_type_o   = result.meta_type;
  assign meta_length_o = result.meta_length;
  assign track_done_o  = result.track_done;

  // A truncated record always closes the track.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == mtep_pkg::KindTruncated |-> track_done_o)
    else $error("truncated result without track_done");

  // Nothing follows the result that ends the track.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && track_done_o |=> !out_valid_o)
    else $error("result after end of track");

  // Meta payload records carry the meta channel code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == mtep_pkg::KindMetaData |->
      channel_o == mtep_pkg::MetaChannel)
    else $error("meta payload with wrong channel");

  // Only pitch bend fills the bend word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bend_word_o != 16'h0000 |-> event_kind_o == mtep_pkg::KindBend)
    else $error("bend word set on non-bend result");

endmodule

// ===== design/mtep_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_front: byte classifier
// Tags each incoming byte with the status codes the parser branches on.
// ----------------------------------------------------------------------------
module mtep_front (
  input  logic [7:0]      byte_value_i,
  input  logic            last_byte_i,
  output mtep_pkg::token_t token_o
);

  always_comb begin
    token_o.byte_value      = byte_value_i;
    token_o.last_byte       = last_byte_i;
    token_o.is_status       = (byte_value_i & mtep_pkg::StatusBit) != 8'h00;
    token_o.is_chan_status  = token_o.is_status &&
                              ((byte_value_i & mtep_pkg::StatusHighMask) !=
                               mtep_pkg::StatusHighMask);
    token_o.is_meta         = byte_value_i == mtep_pkg::MetaStatus;
    token_o.is_sysex        = byte_value_i == mtep_pkg::SysexStatus;
    token_o.is_sysex_end    = byte_value_i == mtep_pkg::SysexEnd;
    token_o.is_end_of_track = byte_value_i == mtep_pkg::MetaEndOfTrack;
  end

endmodule

// ===== design/mtep_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_queue: token queue
// Small register queue that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
module mtep_queue #(
  parameter int unsigned Depth = mtep_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mtep_pkg::token_t push_token_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mtep_pkg::token_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mtep_pkg::token_t entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == FullCnt;
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

// ===== design/mtep_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_back: event parser and result register
// Runs the track grammar over queued tokens, one token per cycle while the result register is free.
// ----------------------------------------------------------------------------
module mtep_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             token_valid_i,
  input  mtep_pkg::token_t token_i,
  output logic             token_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtep_pkg::result_t result_o
);

  typedef enum logic [3:0] {
    PhDelta  = 4'd0,
    PhStatus = 4'd1,
    PhData1  = 4'd2,
    PhData2  = 4'd3,
    PhMType  = 4'd4,
    PhMLen   = 4'd5,
    PhMData  = 4'd6,
    PhSysex  = 4'd7,
    PhSkip   = 4'd8
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        running_q, running_d;
  logic [3:0]        chan_q, chan_d;
  logic [27:0]       delta_q, delta_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic [7:0]        held_q, held_d;
  logic [7:0]        mtype_q, mtype_d;
  logic [7:0]        mrem_q, mrem_d;
  logic              finished_q, finished_d;
  logic              out_valid_q, out_valid_d;
  mtep_pkg::result_t out_q, out_d;

  mtep_pkg::result_t   res;
  mtep_pkg::event_kind_e chan_kind;
  logic              can_adv;
  logic              have, complete, restart, eot;
  logic [27:0]       delta_base;
  logic [7:0]        b;

  assign can_adv     = !out_valid_q || !out_stall_i;
  assign token_pop_o = token_valid_i && can_adv;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
  assign b           = token_i.byte_value;
  assign chan_kind   = mtep_pkg::event_kind_e'(running_q[7:4] - 4'd8);

  always_comb begin
    phase_d    = phase_q;
    running_d  = running_q;
    chan_d     = chan_q;
    delta_d    = delta_q;
    dcnt_d     = dcnt_q;
    held_d     = held_q;
    mtype_d    = mtype_q;
    mrem_d     = mrem_q;
    finished_d = finished_q;
    have       = 1'b0;
    complete   = 1'b0;
    restart    = 1'b0;
    eot        = 1'b0;
    delta_base = (dcnt_q == 3'd0) ? 28'd0 : delta_q;
    res        = '0;

    unique case (phase_q)
      PhStatus: begin
        if (token_i.is_status) begin
          if (token_i.is_chan_status) begin
            running_d = b;
            chan_d    = b[3:0];
            phase_d   = PhData1;
          end else if (token_i.is_meta) begin
            phase_d = PhMType;
          end else if (token_i.is_sysex) begin
            phase_d = PhSysex;
          end else begin
            held_d  = b;
            phase_d = PhSkip;
          end
        end else if (running_q == 8'h00) begin
          restart = 1'b1;
        end else if (chan_kind == mtep_pkg::KindProgram ||
                     chan_kind == mtep_pkg::KindChanPress) begin
          res.event_kind = chan_kind;
          res.channel    = chan_q;
          res.data_first = b;
          have           = 1'b1;
          complete       = 1'b1;
        end else begin
          held_d  = b;
          phase_d = PhData2;
        end
      end
      PhData1: begin
        if (chan_kind == mtep_pkg::KindProgram ||
            chan_kind == mtep_pkg::KindChanPress) begin
          res.event_kind = chan_kind;
          res.channel    = chan_q;
          res.data_first = b;
          have           = 1'b1;
          complete       = 1'b1;
        end else begin
          held_d  = b;
          phase_d = PhData2;
        end
      end
      PhData2: begin
        res.event_kind  = chan_kind;
        res.channel     = chan_q;
        res.data_first  = held_q;
        res.data_second = b;
        res.bend_word   = (chan_kind == mtep_pkg::KindBend) ? {held_q, b} : 16'h0000;
        have            = 1'b1;
        complete        = 1'b1;
      end
      PhMType: begin
        mtype_d = b;
        if (token_i.is_end_of_track) begin
          res.event_kind = mtep_pkg::KindMeta;
          res.channel    = mtep_pkg::MetaChannel;
          res.meta_type  = b;
          res.track_done = 1'b1;
          finished_d     = 1'b1;
          have           = 1'b1;
          eot            = 1'b1;
        end else begin
          phase_d = PhMLen;
        end
      end
      PhMLen: begin
        held_d          = b;
        mrem_d          = b;
        res.event_kind  = mtep_pkg::KindMeta;
        res.channel     = mtep_pkg::MetaChannel;
        res.meta_type   = mtype_q;
        res.meta_length = b;
        have            = 1'b1;
        if (b == 8'h00) begin
          complete = 1'b1;
        end else begin
          phase_d = PhMData;
        end
      end
      PhMData: begin
        res.event_kind  = mtep_pkg::KindMetaData;
        res.channel     = mtep_pkg::MetaChannel;
        res.data_first  = b;
        res.meta_type   = mtype_q;
        res.meta_length = held_q;
        have            = 1'b1;
        mrem_d          = mrem_q - 8'd1;
        complete        = mrem_d == 8'h00;
      end
      PhSysex: begin
        if (token_i.is_sysex_end) begin
          res.event_kind = mtep_pkg::KindSysex;
          have           = 1'b1;
          complete       = 1'b1;
        end
      end
      PhSkip: begin
        res.event_kind = mtep_pkg::KindMeta;
        res.channel    = held_q[3:0];
        res.data_first = b;
        have           = 1'b1;
        complete       = 1'b1;
      end
      default: begin
        delta_d = {delta_base[20:0], b[6:0]};
        dcnt_d  = dcnt_q + 3'd1;
        if (!token_i.is_status || dcnt_d >= 3'd4) begin
          phase_d = PhStatus;
        end else begin
          phase_d = PhDelta;
        end
      end
    endcase

    // The final byte of the chunk closes the track, with whatever event it
    // completes or else with a truncated marker.
    if (token_i.last_byte && !eot) begin
      finished_d = 1'b1;
      if (!complete) begin
        res            = '0;
        res.event_kind = mtep_pkg::KindTruncated;
        res.data_first = b;
      end
      res.track_done = 1'b1;
      have           = 1'b1;
    end

    if (complete || restart) begin
      phase_d = PhDelta;
      dcnt_d  = 3'd0;
    end

    res.delta_ticks = delta_d;

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (can_adv) begin
      out_valid_d = token_valid_i && have && !finished_q;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhDelta;
      running_q   <= 8'h00;
      chan_q      <= 4'h0;
      delta_q     <= 28'd0;
      dcnt_q      <= 3'd0;
      held_q      <= 8'h00;
      mtype_q     <= 8'h00;
      mrem_q      <= 8'h00;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (token_pop_o && !finished_q) begin
        phase_q    <= phase_d;
        running_q  <= running_d;
        chan_q     <= chan_d;
        delta_q    <= delta_d;
        dcnt_q     <= dcnt_d;
        held_q     <= held_d;
        mtype_q    <= mtype_d;
        mrem_q     <= mrem_d;
        finished_q <= finished_d;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

endmodule
